// File: rtl/oklt_pkg.sv
// shared constants, field widths and operation codes of the ordered keyed list table
package oklt_pkg;

   localparam int unsigned CAPACITY = 16;
   localparam int unsigned IDX_W    = $clog2(CAPACITY);
   localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned KEY_W    = 16;
   localparam int unsigned BAL_W    = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned POS_W    = 4;
   localparam int unsigned COUNT_W  = 5;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_FRONT   = 3'd0;
   localparam opcode_type OP_END     = 3'd1;
   localparam opcode_type OP_ORDERED = 3'd2;
   localparam opcode_type OP_REMOVE  = 3'd3;
   localparam opcode_type OP_SEARCH  = 3'd4;
   localparam opcode_type OP_CHANGE  = 3'd5;
   localparam opcode_type OP_CLEAR   = 3'd6;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;

endpackage

// File: rtl/oklt_if.sv
// request and response channel interfaces of the ordered keyed list table
interface oklt_req_if;
   import oklt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPCODE_W-1:0]     opcode;
   logic [KEY_W-1:0]        key;
   logic [KEY_W-1:0]        new_key;
   logic signed [BAL_W-1:0] balance;

   modport source (output valid, opcode, key, new_key, balance, input ready);
   modport sink   (input valid, opcode, key, new_key, balance, output ready);
endinterface

interface oklt_rsp_if;
   import oklt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic signed [BAL_W-1:0] found_balance;
   logic [POS_W-1:0]        position;
   logic [COUNT_W-1:0]      entry_count;
   logic                    is_empty;

   modport source (output valid, status, found_balance, position, entry_count, is_empty,
                   input ready);
   modport sink   (input valid, status, found_balance, position, entry_count, is_empty,
                   output ready);
endinterface

// File: rtl/ordered_keyed_list_table.sv
// top level of the ordered keyed list table: walk and shift sequencer over a register file
//
//  channel   direction   handshake       payload
//  req_chan  in          valid / ready   opcode, key, new_key, balance
//  rsp_chan  out         valid / ready   status, found_balance, position, entry_count, is_empty
//
// one transaction at a time: req_chan.ready is high only while the sequencer is idle
// clear, full and unknown transactions go straight to the response; the others walk the list,
// one entry compared or moved per cycle over one read port
// the result waits in an output register; a stalled response holds the sequencer at its end
// reset is synchronous and empties the list; stored entries are not cleared
module ordered_keyed_list_table (
   input  logic       clock,
   input  logic       reset,
   oklt_req_if.sink   req_chan,
   oklt_rsp_if.source rsp_chan
);
   import oklt_pkg::*;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_SCAN       = 3'd1;
   localparam logic [2:0] ST_SHIFT_UP   = 3'd2;
   localparam logic [2:0] ST_SHIFT_DOWN = 3'd3;
   localparam logic [2:0] ST_DONE       = 3'd4;

   logic [KEY_W-1:0]        key_mem [CAPACITY];
   logic signed [BAL_W-1:0] bal_mem [CAPACITY];

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   opcode_type              op_ff, op_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [KEY_W-1:0]        nkey_ff, nkey_in;
   logic signed [BAL_W-1:0] bal_ff, bal_in;
   status_type              status_ff, status_in;
   logic signed [BAL_W-1:0] found_ff, found_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic signed [BAL_W-1:0] rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic                    req_fire;
   logic [CNT_W-1:0]        idx_p1, idx_m1;
   logic [IDX_W-1:0]        rd_idx, wr_idx;
   logic [KEY_W-1:0]        rd_key, wr_key;
   logic signed [BAL_W-1:0] rd_bal, wr_bal;
   logic                    wr_key_en, wr_bal_en;
   logic                    at_end, key_hit, bal_hit, scan_hit;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // shared step unit of the walk
   assign idx_p1 = idx_ff + CNT_W'(1);
   assign idx_m1 = idx_ff - CNT_W'(1);

   always_comb begin
      case (state_ff)
         ST_SHIFT_UP:   rd_idx = idx_m1[IDX_W-1:0];
         ST_SHIFT_DOWN: rd_idx = idx_p1[IDX_W-1:0];
         default:       rd_idx = idx_ff[IDX_W-1:0];
      endcase
   end

   assign rd_key   = key_mem[rd_idx];
   assign rd_bal   = bal_mem[rd_idx];
   assign at_end   = (idx_ff == count_ff);
   assign key_hit  = (rd_key == key_ff);
   assign bal_hit  = !(rd_bal < bal_ff);
   assign scan_hit = (op_ff == OP_ORDERED) ? bal_hit : key_hit;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      nkey_in       = nkey_ff;
      bal_in        = bal_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      wr_key_en     = 1'b0;
      wr_bal_en     = 1'b0;
      wr_idx        = idx_ff[IDX_W-1:0];
      wr_key        = rd_key;
      wr_bal        = rd_bal;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.opcode;
               key_in    = req_chan.key;
               nkey_in   = req_chan.new_key;
               bal_in    = req_chan.balance;
               status_in = STATUS_DONE;
               found_in  = '0;
               pos_in    = '0;
               idx_in    = '0;
               case (req_chan.opcode) inside
                  OP_FRONT, OP_END, OP_ORDERED: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_DONE;
                     end else if (req_chan.opcode == OP_ORDERED) begin
                        state_in = ST_SCAN;
                     end else begin
                        pos_in   = (req_chan.opcode == OP_FRONT) ? '0 : count_ff;
                        idx_in   = count_ff;
                        state_in = ST_SHIFT_UP;
                     end
                  end
                  OP_REMOVE, OP_SEARCH, OP_CHANGE: begin
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (at_end) begin
               if (op_ff == OP_ORDERED) begin
                  pos_in   = idx_ff;
                  state_in = ST_SHIFT_UP;
               end else begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = ST_DONE;
               end
            end else if (scan_hit) begin
               pos_in = idx_ff;
               case (op_ff)
                  OP_ORDERED: begin
                     idx_in   = count_ff;
                     state_in = ST_SHIFT_UP;
                  end
                  OP_REMOVE: begin
                     state_in = ST_SHIFT_DOWN;
                  end
                  OP_SEARCH: begin
                     found_in = rd_bal;
                     state_in = ST_DONE;
                  end
                  default: begin
                     wr_key_en = 1'b1;
                     wr_key    = nkey_ff;
                     state_in  = ST_DONE;
                  end
               endcase
            end else begin
               idx_in = idx_p1;
            end
         end
         ST_SHIFT_UP: begin
            wr_key_en = 1'b1;
            wr_bal_en = 1'b1;
            if (idx_ff == pos_ff) begin
               // gap has reached the insert point
               wr_key   = key_ff;
               wr_bal   = bal_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               idx_in = idx_m1;
            end
         end
         ST_SHIFT_DOWN: begin
            if (idx_p1 >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               wr_key_en = 1'b1;
               wr_bal_en = 1'b1;
               idx_in    = idx_p1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_pos_in    = pos_ff[POS_W-1:0];
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      nkey_ff       <= nkey_in;
      bal_ff        <= bal_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_idx] <= wr_key;
      end
      if (wr_bal_en) begin
         bal_mem[wr_idx] <= wr_bal;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.found_balance = rsp_found_ff;
   assign rsp_chan.position      = rsp_pos_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;
   assign rsp_chan.is_empty      = rsp_empty_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("sequencer idle right after an accepted transaction");

   a_count_held_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !req_fire |=> $stable(count_ff))
      else $error("entry count moved while idle");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.is_empty == (rsp_chan.entry_count == '0)))
      else $error("empty flag disagrees with entry count");

endmodule
